// ===== sv/ffha_pkg.sv =====
// Shared constants, header layout and memory request types for the
// first-fit heap allocator. No dependencies.
package ffha_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int ALIGN_BYTES  = 8;
	localparam int HEADER_BYTES = 16;
	localparam int HEAP_TOTAL   = ((HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

	localparam int OFF_W       = 12;
	localparam int SIZE_W      = 13;
	localparam int REQ_W       = 13;
	localparam int RND_W       = 14;
	localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
	localparam int DEPTH       = HEAP_TOTAL / ALIGN_BYTES;
	localparam int IDX_W       = $clog2(DEPTH);

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_REINIT = 2'd3;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  next;
		logic              free;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		hdr_t             wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              status;
		logic [OFF_W-1:0]  address;
		logic [SIZE_W-1:0] copy;
	} res_t;

endpackage

// ===== sv/ffha_hdr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffha_hdr_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ffha_ctrl.sv =====
// Sequencer that walks the header chain and performs alloc, free, resize and reinit.
// Depends on ffha_pkg; drives the header RAM through a mem_req_t.
module ffha_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [ffha_pkg::REQ_W-1:0]     request_bytes,
	input  logic [ffha_pkg::OFF_W-1:0]     block_address,
	output ffha_pkg::mem_req_t             mem_req,
	input  logic [ffha_pkg::HDR_W-1:0]     mem_rdata,
	input  logic                           out_free,
	output logic                           done,
	output ffha_pkg::res_t                 res
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_TAKE  = 4'd4;
	localparam logic [3:0] S_FRD   = 4'd5;
	localparam logic [3:0] S_FBLK  = 4'd6;
	localparam logic [3:0] S_FNX   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam logic [ffha_pkg::RND_W-1:0] HDR_R = ffha_pkg::RND_W'(ffha_pkg::HEADER_BYTES);
	localparam logic [ffha_pkg::SIZE_W-1:0] HDR_S = ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
	localparam logic [ffha_pkg::RND_W-1:0] AMASK = ffha_pkg::RND_W'(ffha_pkg::ALIGN_BYTES - 1);

	logic [3:0]                     state_q;
	logic                           alloc_mode_q;
	logic                           moved_q;
	logic                           split_q;
	logic                           head_valid_q;
	logic                           zero_s1;
	logic [1:0]                     op_q;
	logic [ffha_pkg::RND_W-1:0]     size_q;
	logic [ffha_pkg::OFF_W-1:0]     addr_q;
	logic [ffha_pkg::OFF_W-1:0]     cur_q;
	logic [ffha_pkg::OFF_W-1:0]     blk_q;
	ffha_pkg::hdr_t                 hdr_q;
	ffha_pkg::res_t                 res_q;

	ffha_pkg::hdr_t                 rd_hdr;
	ffha_pkg::hdr_t                 reset_hdr;
	logic [ffha_pkg::RND_W-1:0]     size_rnd;
	logic [ffha_pkg::SIZE_W-1:0]    cur_pay;
	logic [ffha_pkg::OFF_W-1:0]     nb_off;
	logic                           match;
	logic                           fits;
	logic                           accept;

	function automatic logic [ffha_pkg::IDX_W-1:0] idx(input logic [ffha_pkg::OFF_W-1:0] off);
		return off[ffha_pkg::OFF_W-1:ffha_pkg::ALIGN_SHIFT];
	endfunction

	assign reset_hdr.size = ffha_pkg::SIZE_W'(ffha_pkg::HEAP_TOTAL - ffha_pkg::HEADER_BYTES);
	assign reset_hdr.next = '0;
	assign reset_hdr.free = 1'b1;

	assign rd_hdr   = zero_s1 ? reset_hdr : ffha_pkg::hdr_t'(mem_rdata);
	assign size_rnd = ({1'b0, request_bytes} + AMASK) & ~AMASK;
	assign cur_pay  = {1'b0, cur_q} + HDR_S;
	assign nb_off   = cur_q + size_q[ffha_pkg::OFF_W-1:0] + HDR_S[ffha_pkg::OFF_W-1:0];
	assign match    = cur_pay == {1'b0, addr_q};
	assign fits     = rd_hdr.free && ({1'b0, rd_hdr.size} >= size_q);
	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign done     = (state_q == S_DONE) && out_free;
	assign res      = res_q;

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx(cur_q);
			end
			S_SPLIT: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = idx(nb_off);
				mem_req.wdata.size = hdr_q.size - size_q[ffha_pkg::SIZE_W-1:0] - HDR_S;
				mem_req.wdata.next = hdr_q.next;
				mem_req.wdata.free = 1'b1;
			end
			S_TAKE: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = idx(cur_q);
				mem_req.wdata.size = split_q ? size_q[ffha_pkg::SIZE_W-1:0] : hdr_q.size;
				mem_req.wdata.next = split_q ? nb_off : hdr_q.next;
				mem_req.wdata.free = 1'b0;
			end
			S_FRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx(blk_q);
			end
			S_FBLK: begin
				if (rd_hdr.next == '0) begin
					mem_req.we         = 1'b1;
					mem_req.waddr      = idx(blk_q);
					mem_req.wdata.size = rd_hdr.size;
					mem_req.wdata.next = rd_hdr.next;
					mem_req.wdata.free = 1'b1;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx(rd_hdr.next);
				end
			end
			S_FNX: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = idx(blk_q);
				mem_req.wdata.size = rd_hdr.free ? hdr_q.size + HDR_S + rd_hdr.size : hdr_q.size;
				mem_req.wdata.next = rd_hdr.free ? rd_hdr.next : hdr_q.next;
				mem_req.wdata.free = 1'b1;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			zero_s1      <= 1'b0;
		end else begin
			if (accept && operation == ffha_pkg::OP_REINIT) begin
				head_valid_q <= 1'b0;
			end else if (mem_req.we && mem_req.waddr == '0) begin
				head_valid_q <= 1'b1;
			end
			if (mem_req.re) begin
				zero_s1 <= (mem_req.raddr == '0) && !head_valid_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							ffha_pkg::OP_ALLOC:  state_q <= S_RD;
							ffha_pkg::OP_FREE:   state_q <= (block_address == '0) ? S_DONE : S_RD;
							ffha_pkg::OP_RESIZE: state_q <= S_RD;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (alloc_mode_q) begin
						if (fits) begin
							state_q <= ({1'b0, rd_hdr.size} > size_q + HDR_R) ? S_SPLIT : S_TAKE;
						end else begin
							state_q <= (rd_hdr.next == '0) ? S_DONE : S_RD;
						end
					end else if (match) begin
						if (op_q == ffha_pkg::OP_FREE || size_q == '0) begin
							state_q <= S_FRD;
						end else if (rd_hdr.free || {1'b0, rd_hdr.size} >= size_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						state_q <= (rd_hdr.next == '0) ? S_DONE : S_RD;
					end
				end
				S_SPLIT: state_q <= S_TAKE;
				S_TAKE:  state_q <= moved_q ? S_FRD : S_DONE;
				S_FRD:   state_q <= S_FBLK;
				S_FBLK:  state_q <= (rd_hdr.next == '0) ? S_DONE : S_FNX;
				S_FNX:   state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= operation;
					size_q       <= size_rnd;
					addr_q       <= block_address;
					cur_q        <= '0;
					moved_q      <= 1'b0;
					alloc_mode_q <= (operation == ffha_pkg::OP_ALLOC) || (block_address == '0);
					res_q        <= '0;
				end
			end
			S_CHK: begin
				if (alloc_mode_q) begin
					if (fits) begin
						hdr_q   <= rd_hdr;
						split_q <= {1'b0, rd_hdr.size} > size_q + HDR_R;
					end else if (rd_hdr.next == '0) begin
						res_q.status <= 1'b1;
						res_q.copy   <= '0;
					end else begin
						cur_q <= rd_hdr.next;
					end
				end else if (match) begin
					blk_q <= cur_q;
					if (op_q == ffha_pkg::OP_FREE || size_q == '0) begin
						res_q <= '0;
					end else if (rd_hdr.free) begin
						res_q.status <= 1'b1;
					end else if ({1'b0, rd_hdr.size} >= size_q) begin
						res_q.address <= addr_q;
					end else begin
						res_q.copy   <= rd_hdr.size;
						alloc_mode_q <= 1'b1;
						moved_q      <= 1'b1;
						cur_q        <= '0;
					end
				end else if (rd_hdr.next == '0) begin
					res_q.status <= (op_q == ffha_pkg::OP_RESIZE) && (size_q != '0);
				end else begin
					cur_q <= rd_hdr.next;
				end
			end
			S_TAKE: res_q.address <= cur_pay[ffha_pkg::OFF_W-1:0];
			S_FBLK: hdr_q <= rd_hdr;
			default: begin
			end
		endcase
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("header RAM read and write in one cycle");

	a_read_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |=> (state_q == S_CHK || state_q == S_FBLK || state_q == S_FNX))
		else $error("header read data not consumed");

	a_split_apart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPLIT |-> mem_req.waddr != idx(cur_q))
		else $error("split header overwrites the granted block");

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator: header RAM, chain-walk sequencer, output register.
// Work per item: one RAM read per header visited on the chain walk, plus
// up to 2 writes for a grant and 2 reads plus 1 write for a free, and the
// output register load; resize chains a lookup walk, an allocate walk and
// a free. One item at a time; a held result stalls the input.
// Reset: asynchronous; heap holds one free block, and reinit restores it.
module first_fit_heap_allocator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [ffha_pkg::REQ_W-1:0] request_bytes,
	input  logic [ffha_pkg::OFF_W-1:0] block_address,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       status,
	output logic [ffha_pkg::OFF_W-1:0] result_address,
	output logic [ffha_pkg::SIZE_W-1:0] copy_bytes
);

	ffha_pkg::mem_req_t         mem_req;
	logic [ffha_pkg::HDR_W-1:0] mem_rdata;
	logic                       out_free;
	logic                       done;
	ffha_pkg::res_t             res;
	logic                       out_valid_q;
	ffha_pkg::res_t             out_q;

	assign out_free = !out_valid_q || out_ready;

	ffha_hdr_ram #(
		.DEPTH(ffha_pkg::DEPTH),
		.WIDTH(ffha_pkg::HDR_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	ffha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.request_bytes(request_bytes),
		.block_address(block_address),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.out_free     (out_free),
		.done         (done),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign result_address = out_q.address;
	assign copy_bytes     = out_q.copy;

endmodule

// ===== verif/tb_first_fit_heap_allocator_unit.sv =====
// Self-checking testbench for first_fit_heap_allocator_unit: predicts each result
// from a behavioral heap model and checks it. Depends on ffha_pkg and the unit.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD      = 400;

	typedef struct {
		logic                        status;
		logic [ffha_pkg::OFF_W-1:0]  address;
		logic [ffha_pkg::SIZE_W-1:0] copy;
	} grant_t;

	typedef struct {
		int unsigned size;
		int unsigned next;
		bit          free;
	} blk_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [ffha_pkg::REQ_W-1:0] request_bytes;
	logic [ffha_pkg::OFF_W-1:0] block_address;
	logic out_valid;
	logic out_ready;
	logic status;
	logic [ffha_pkg::OFF_W-1:0] result_address;
	logic [ffha_pkg::SIZE_W-1:0] copy_bytes;

	blk_t heap_hdr [ffha_pkg::HEAP_TOTAL];
	grant_t pending_grants[$];
	int unsigned live_addrs[$];
	int errors;
	int idle_cycles;
	bit rx_idle_en;
	bit tx_idle_en;
	int rx_hold;
	int hold_req;
	int hold_seen;

	first_fit_heap_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_bytes(request_bytes),
		.block_address(block_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_address(result_address), .copy_bytes(copy_bytes)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int unsigned align_up(int unsigned n);
		return ((n + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES)
			* ffha_pkg::ALIGN_BYTES;
	endfunction

	function automatic void model_reset();
		heap_hdr[0].size = ffha_pkg::HEAP_TOTAL - ffha_pkg::HEADER_BYTES;
		heap_hdr[0].next = 0;
		heap_hdr[0].free = 1;
	endfunction

	function automatic int heap_find(int unsigned addr);
		int unsigned cur;
		int unsigned steps;
		cur = 0;
		steps = 0;
		if (addr == 0)
			return -1;
		forever begin
			if (cur >= ffha_pkg::HEAP_TOTAL || steps > ffha_pkg::HEAP_TOTAL)
				return -1;
			if (cur + ffha_pkg::HEADER_BYTES == addr)
				return cur;
			cur = heap_hdr[cur].next;
			steps++;
			if (cur == 0)
				return -1;
		end
	endfunction

	function automatic int unsigned heap_take(int unsigned sz);
		int unsigned cur;
		int unsigned steps;
		int unsigned nb;
		cur = 0;
		steps = 0;
		forever begin
			if (cur >= ffha_pkg::HEAP_TOTAL || steps > ffha_pkg::HEAP_TOTAL)
				return 0;
			if (heap_hdr[cur].free && heap_hdr[cur].size >= sz) begin
				if (heap_hdr[cur].size > sz + ffha_pkg::HEADER_BYTES) begin
					nb = cur + ffha_pkg::HEADER_BYTES + sz;
					if (nb < ffha_pkg::HEAP_TOTAL) begin
						heap_hdr[nb].size = heap_hdr[cur].size - sz - ffha_pkg::HEADER_BYTES;
						heap_hdr[nb].free = 1;
						heap_hdr[nb].next = heap_hdr[cur].next;
						heap_hdr[cur].next = nb;
						heap_hdr[cur].size = sz;
					end
				end
				heap_hdr[cur].free = 0;
				return cur + ffha_pkg::HEADER_BYTES;
			end
			cur = heap_hdr[cur].next;
			steps++;
			if (cur == 0)
				return 0;
		end
	endfunction

	function automatic void heap_release(int unsigned b);
		int unsigned nx;
		if (b >= ffha_pkg::HEAP_TOTAL)
			return;
		heap_hdr[b].free = 1;
		nx = heap_hdr[b].next;
		if (nx != 0 && nx < ffha_pkg::HEAP_TOTAL && heap_hdr[nx].free) begin
			heap_hdr[b].size += ffha_pkg::HEADER_BYTES + heap_hdr[nx].size;
			heap_hdr[b].next = heap_hdr[nx].next;
		end
	endfunction

	function automatic grant_t heap_apply(logic [1:0] op, int unsigned req, int unsigned addr);
		grant_t g;
		int unsigned sz;
		int unsigned old_sz;
		int unsigned r;
		int b;
		g.status = 0;
		g.address = '0;
		g.copy = '0;
		sz = align_up(req);
		r = 0;
		case (op)
			ffha_pkg::OP_ALLOC: begin
				r = heap_take(sz);
				g.status = (r == 0);
			end
			ffha_pkg::OP_FREE: begin
				b = heap_find(addr);
				if (b >= 0)
					heap_release(b);
			end
			ffha_pkg::OP_RESIZE: begin
				if (addr == 0) begin
					r = heap_take(sz);
					g.status = (r == 0);
				end else if (sz == 0) begin
					b = heap_find(addr);
					if (b >= 0)
						heap_release(b);
				end else begin
					b = heap_find(addr);
					if (b < 0 || heap_hdr[b].free) begin
						g.status = 1;
					end else if (heap_hdr[b].size >= sz) begin
						r = addr;
					end else begin
						old_sz = heap_hdr[b].size;
						r = heap_take(sz);
						if (r == 0) begin
							g.status = 1;
						end else begin
							g.copy = old_sz[ffha_pkg::SIZE_W-1:0];
							heap_release(b);
						end
					end
				end
			end
			default: model_reset();
		endcase
		g.address = r[ffha_pkg::OFF_W-1:0];
		return g;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic send_item(logic [1:0] op, int unsigned req, int unsigned addr);
		grant_t g;
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= req[ffha_pkg::REQ_W-1:0];
		block_address <= addr[ffha_pkg::OFF_W-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		g = heap_apply(op, req, addr);
		pending_grants.push_back(g);
		if (op == ffha_pkg::OP_REINIT)
			live_addrs.delete();
		else if ((op == ffha_pkg::OP_ALLOC || op == ffha_pkg::OP_RESIZE)
			&& g.status == 0 && g.address != 0)
			live_addrs.push_back(g.address);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic int unsigned pick_addr();
		if (live_addrs.size() != 0 && $urandom_range(0, 7) != 0)
			return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
		return $urandom_range(0, 4095);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			out_ready <= 1'b0;
			rx_hold <= LONG_HOLD;
			hold_seen <= hold_req;
		end else if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_idle_en && out_ready && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			rx_hold <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t g;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result", result_address, 0);
			end else begin
				g = pending_grants.pop_front();
				if (status !== g.status)
					report_mismatch("status", status, g.status);
				if (result_address !== g.address)
					report_mismatch("result_address", result_address, g.address);
				if (copy_bytes !== g.copy)
					report_mismatch("copy_bytes", copy_bytes, g.copy);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("first_fit_heap_allocator_unit regression: fail");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(ffha_pkg::OP_ALLOC, 0, 0);
		send_item(ffha_pkg::OP_ALLOC, 1, 0);
		send_item(ffha_pkg::OP_ALLOC, 4096, 0);
		send_item(ffha_pkg::OP_ALLOC, 8191, 0);
		send_item(ffha_pkg::OP_FREE, 0, 0);
		send_item(ffha_pkg::OP_FREE, 0, 4095);
		send_item(ffha_pkg::OP_FREE, 0, 16);
		send_item(ffha_pkg::OP_FREE, 0, 16);
		send_item(ffha_pkg::OP_RESIZE, 24, 0);
		send_item(ffha_pkg::OP_RESIZE, 8, pick_addr());
		send_item(ffha_pkg::OP_RESIZE, 200, pick_addr());
		send_item(ffha_pkg::OP_RESIZE, 4000, pick_addr());
		send_item(ffha_pkg::OP_RESIZE, 0, pick_addr());
		send_item(ffha_pkg::OP_RESIZE, 40, 2730);
		send_item(ffha_pkg::OP_REINIT, 8191, 4095);
		send_item(ffha_pkg::OP_ALLOC, ffha_pkg::HEAP_TOTAL - ffha_pkg::HEADER_BYTES, 0);
		send_item(ffha_pkg::OP_ALLOC, 0, 0);
		send_item(ffha_pkg::OP_REINIT, 0, 0);
		send_item(ffha_pkg::OP_ALLOC, ffha_pkg::HEAP_TOTAL - 2 * ffha_pkg::HEADER_BYTES, 0);
		send_item(ffha_pkg::OP_REINIT, 5461, 1365);
	endtask

	task automatic test_random(int n);
		int k;
		int unsigned r;
		int unsigned req;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			req = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
				: $urandom_range(0, 300);
			if (r < 45)
				send_item(ffha_pkg::OP_ALLOC, req, $urandom_range(0, 4095));
			else if (r < 75)
				send_item(ffha_pkg::OP_FREE, $urandom_range(0, 8191), pick_addr());
			else if (r < 97)
				send_item(ffha_pkg::OP_RESIZE, ($urandom_range(0, 9) == 0) ? 0 : req,
					($urandom_range(0, 9) == 0) ? 0 : pick_addr());
			else
				send_item(ffha_pkg::OP_REINIT, $urandom_range(0, 8191),
					$urandom_range(0, 4095));
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		test_random(30);
		drain();
	endtask

	initial begin
		rx_idle_en = 0;
		tx_idle_en = 0;
		in_valid = 1'b0;
		operation = ffha_pkg::OP_ALLOC;
		request_bytes = '0;
		block_address = '0;
		model_reset();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		rx_idle_en = 1;
		tx_idle_en = 1;
		test_random(600);
		drain();
		test_backpressure();
		rx_idle_en = 0;
		tx_idle_en = 0;
		test_random(380);
		drain();
		if (errors == 0)
			$display("first_fit_heap_allocator_unit regression: pass");
		else
			$display("first_fit_heap_allocator_unit regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ffha_pkg.sv
sv/ffha_hdr_ram.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator_unit.sv
verif/tb_first_fit_heap_allocator_unit.sv
